// File: rtl/core/i2cmrs_pkg.sv
`timescale 1ns / 1ps

package i2cmrs_pkg;

    // Depth of the receive buffer; a longer read length is cut to this.
    localparam int BUFFER_DEPTH = 16;

    // Largest read length the five-bit register can express.
    localparam int READ_LENGTH_MAX = 31;
    localparam logic [4:0] LEN_CAP =
        5'((BUFFER_DEPTH > READ_LENGTH_MAX) ? READ_LENGTH_MAX : BUFFER_DEPTH);

    // Configuration register indexes.
    localparam logic [7:0] REG_TARGET_ADDR   = 8'd0;
    localparam logic [7:0] REG_READ_LENGTH   = 8'd1;
    localparam logic [7:0] REG_RETRY_LIMIT   = 8'd2;
    localparam logic [7:0] REG_TIMEOUT_LIMIT = 8'd3;

    // Register reset values.
    localparam logic [6:0]  RST_TARGET_ADDR   = 7'd0;
    localparam logic [4:0]  RST_READ_LENGTH   = 5'd2;
    localparam logic [2:0]  RST_RETRY_LIMIT   = 3'd5;
    localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd10000;

    // Input item modes.
    localparam logic MODE_POLL  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Finish status codes.
    localparam logic [1:0] FINISH_NONE = 2'd0;
    localparam logic [1:0] FINISH_OK   = 2'd1;
    localparam logic [1:0] FINISH_FAIL = 2'd2;

    // Sequencer phase codes.
    localparam logic [3:0] PH_START  = 4'd0;
    localparam logic [3:0] PH_ADDR   = 4'd1;
    localparam logic [3:0] PH_ACKW   = 4'd2;
    localparam logic [3:0] PH_RXEN   = 4'd3;
    localparam logic [3:0] PH_RXMID  = 4'd4;
    localparam logic [3:0] PH_RXNEXT = 4'd5;
    localparam logic [3:0] PH_RXLAST = 4'd6;
    localparam logic [3:0] PH_RSTOP  = 4'd7;
    localparam logic [3:0] PH_RWAIT  = 4'd8;
    localparam logic [3:0] PH_ESTOP  = 4'd9;
    localparam logic [3:0] PH_EWAIT  = 4'd10;
    localparam logic [3:0] PH_NSTOP  = 4'd11;
    localparam logic [3:0] PH_NWAIT  = 4'd12;
    localparam logic [3:0] PH_IDLE   = 4'd15;

    typedef struct packed {
        logic       mode;
        logic       bus_event;
        logic       ack_status;
        logic [7:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic       start_cond;
        logic       addr_valid;
        logic [7:0] addr_byte;
        logic       recv_enable;
        logic       ack_enable;
        logic       ack_level;
        logic       stop_cond;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic [1:0] finish_status;
        logic       nack_seen;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  target_addr;
        logic [4:0]  read_length;
        logic [2:0]  retry_limit;
        logic [15:0] timeout_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  retry_count;
        logic [4:0]  byte_index;
        logic [15:0] elapsed_polls;
        logic        nack_flag;
    } seq_state_t;

endpackage

// File: rtl/core/i2cmrs_step.sv
`timescale 1ns / 1ps

module i2cmrs_step
    import i2cmrs_pkg::*;
(
    input  seq_state_t cur,
    input  cfg_regs_t  cfg,
    input  in_item_t   item,
    output seq_state_t nxt,
    output out_item_t  res
);

    logic        done;
    logic [15:0] elapsed_inc;
    logic [4:0]  len;
    logic [5:0]  byte_inc;

    // Effective read length, saturated to the buffer depth.
    assign len = (cfg.read_length > LEN_CAP) ? LEN_CAP : cfg.read_length;
    assign byte_inc = {1'b0, cur.byte_index} + 6'd1;
    // Cannot wrap: a poll is only counted while below the limit.
    assign elapsed_inc = cur.elapsed_polls + 16'd1;

    // One sequencer step per transfer.
    always_comb begin
        nxt  = cur;
        res  = '0;
        done = 1'b0;
        if (item.mode == MODE_START) begin
            // A start request only arms the sequencer when it is idle.
            if (cur.phase == PH_IDLE) begin
                nxt.phase         = PH_START;
                nxt.retry_count   = 3'd0;
                nxt.byte_index    = 5'd0;
                nxt.elapsed_polls = 16'd0;
            end
        end else if (cur.phase != PH_IDLE) begin
            if (cur.elapsed_polls >= cfg.timeout_limit) begin
                // Poll budget already spent: fail without a stop condition.
                res.finish_status = FINISH_FAIL;
                nxt.phase         = PH_IDLE;
            end else begin
                nxt.elapsed_polls = elapsed_inc;
                unique case (cur.phase)
                    PH_START: begin
                        res.start_cond = 1'b1;
                        nxt.phase      = PH_ADDR;
                    end
                    PH_ADDR: begin
                        if (item.bus_event) begin
                            res.addr_valid = 1'b1;
                            res.addr_byte  = {cfg.target_addr, 1'b1};
                            nxt.phase      = PH_ACKW;
                        end
                    end
                    PH_ACKW: begin
                        if (item.bus_event) begin
                            if (item.ack_status) begin
                                nxt.nack_flag = 1'b1;
                                nxt.phase = (cur.retry_count < cfg.retry_limit) ?
                                            PH_RSTOP : PH_ESTOP;
                            end else begin
                                nxt.nack_flag   = 1'b0;
                                nxt.retry_count = 3'd0;
                                nxt.phase       = PH_RXEN;
                            end
                        end
                    end
                    PH_RXEN: begin
                        res.recv_enable = 1'b1;
                        nxt.phase       = PH_RXMID;
                    end
                    PH_RXMID: begin
                        if (item.bus_event) begin
                            res.rx_valid   = 1'b1;
                            res.rx_index   = cur.byte_index[3:0];
                            res.rx_byte    = item.rx_data;
                            res.ack_enable = 1'b1;
                            nxt.byte_index = byte_inc[4:0];
                            nxt.phase      = PH_RXNEXT;
                        end
                    end
                    PH_RXNEXT: begin
                        if (item.bus_event) begin
                            res.recv_enable = 1'b1;
                            nxt.phase = (byte_inc < {1'b0, len}) ? PH_RXMID : PH_RXLAST;
                        end
                    end
                    PH_RXLAST: begin
                        // The last byte is answered with a NACK.
                        if (item.bus_event) begin
                            res.rx_valid   = 1'b1;
                            res.rx_index   = cur.byte_index[3:0];
                            res.rx_byte    = item.rx_data;
                            res.ack_enable = 1'b1;
                            res.ack_level  = 1'b1;
                            nxt.phase      = PH_NSTOP;
                        end
                    end
                    PH_RSTOP: begin
                        res.stop_cond = 1'b1;
                        nxt.phase     = PH_RWAIT;
                    end
                    PH_RWAIT: begin
                        if (item.bus_event) begin
                            nxt.retry_count = cur.retry_count + 3'd1;
                            nxt.phase       = PH_START;
                        end
                    end
                    PH_ESTOP: begin
                        res.stop_cond = 1'b1;
                        nxt.phase     = PH_EWAIT;
                    end
                    PH_EWAIT: begin
                        if (item.bus_event) begin
                            res.finish_status = FINISH_FAIL;
                            done              = 1'b1;
                        end
                    end
                    PH_NSTOP: begin
                        if (item.bus_event) begin
                            res.stop_cond = 1'b1;
                            nxt.phase     = PH_NWAIT;
                        end
                    end
                    PH_NWAIT: begin
                        if (item.bus_event) begin
                            res.finish_status = FINISH_OK;
                            done              = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
                // The poll that uses up the budget also ends the transaction.
                if (done) begin
                    nxt.phase = PH_IDLE;
                end else if (elapsed_inc >= cfg.timeout_limit) begin
                    res.finish_status = FINISH_FAIL;
                    nxt.phase         = PH_IDLE;
                end
            end
        end
        res.nack_seen = nxt.nack_flag;
    end

endmodule

// File: rtl/core/i2c_master_read_sequencer.sv
`timescale 1ns / 1ps

// I2C master read sequencer.
// The s_ channel carries one transfer per step: a start request (mode 1) arms
// a read while the sequencer is idle, and a poll (mode 0) carries the bus
// controller's completion flag, the address acknowledge and the received byte.
// Every accepted input transfer produces exactly one result transfer on the
// m_ channel with the bus requests for that step, any delivered byte with its
// index, the finish status and the last address NACK flag.
// The cfg_ channel writes the target address, read length, retry limit and
// timeout limit by index; it is always ready and should be used while idle.
// The result is registered and appears in the cycle after its input transfer.
// The step logic sits between the state register and the result register, so a
// new input transfer is taken every cycle as long as the result register is empty
// or being emptied in the same cycle. When the receiver stalls, the result is
// held and s_ready drops until it is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears its
// counters and NACK flag, loads the register defaults and empties the result
// register.
module i2c_master_read_sequencer
    import i2cmrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_regs_t  cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_item_t  result_next;
    out_item_t  m_data_reg;
    logic       m_valid_reg;
    logic       in_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_addr   <= RST_TARGET_ADDR;
            cfg_reg.read_length   <= RST_READ_LENGTH;
            cfg_reg.retry_limit   <= RST_RETRY_LIMIT;
            cfg_reg.timeout_limit <= RST_TIMEOUT_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET_ADDR:   cfg_reg.target_addr   <= cfg_data[6:0];
                REG_READ_LENGTH:   cfg_reg.read_length   <= cfg_data[4:0];
                REG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_data[2:0];
                REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cmrs_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (s_data),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Sequencer state advances on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.retry_count   <= 3'd0;
            state_reg.byte_index    <= 5'd0;
            state_reg.elapsed_polls <= 16'd0;
            state_reg.nack_flag     <= 1'b0;
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= result_next;
        end
    end

    // Every input transfer leaves a result in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid_reg)
        else $error("result register empty after an input transfer");

    // A delivered byte is always paired with an acknowledge request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.rx_valid) |-> m_data_reg.ack_enable)
        else $error("received byte delivered without acknowledge request");

    // The address byte always carries the read bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.addr_valid) |-> m_data_reg.addr_byte[0])
        else $error("address byte without read bit");

    // A finished transaction leaves the sequencer idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (result_next.finish_status != FINISH_NONE))
            |=> (state_reg.phase == PH_IDLE))
        else $error("sequencer busy after finishing");

endmodule

// File: dv/i2c_master_read_sequencer_tb.sv
`timescale 1ns / 1ps

module i2c_master_read_sequencer_tb;
    import i2cmrs_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [15:0] cfg_data;

    i2c_master_read_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the sequencer registers and state.
    logic [6:0]  dev_addr;
    logic [4:0]  rd_len;
    logic [2:0]  retry_max;
    logic [15:0] poll_limit;
    logic [3:0]  seq_phase;
    logic [2:0]  retry_cnt;
    logic [4:0]  byte_cnt;
    logic [15:0] poll_cnt;
    logic        nack_latch;

    // Bus steps predicted for accepted transfers, oldest first.
    out_item_t steps_due[$];
    int        bad_steps;

    // Knobs shared between the stimulus and the receiver.
    bit tx_gaps;
    bit rx_stalls;
    bit hold_req;

    // One row of the directed table: either a register setting or one transfer.
    typedef struct {
        bit          is_cfg;
        logic [6:0]  addr;
        logic [4:0]  len;
        logic [2:0]  retry;
        logic [15:0] tmo;
        in_item_t    item;
        bit          typed;
        out_item_t   step;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // Advance the shadow sequencer by one transfer and return the bus step it causes.
    function automatic out_item_t advance_read_sequence(in_item_t it);
        out_item_t  r;
        logic [4:0] eff_len;
        bit         done;
        r = out_item_t'(0);
        done = 1'b0;
        eff_len = (rd_len > LEN_CAP) ? LEN_CAP : rd_len;
        if (it.mode == MODE_START) begin
            if (seq_phase == PH_IDLE) begin
                seq_phase = PH_START;
                retry_cnt = '0;
                byte_cnt = '0;
                poll_cnt = '0;
            end
        end else if (seq_phase != PH_IDLE) begin
            if (poll_cnt >= poll_limit) begin
                r.finish_status = FINISH_FAIL;
                seq_phase = PH_IDLE;
            end else begin
                poll_cnt = poll_cnt + 16'd1;
                case (seq_phase)
                    PH_START: begin
                        r.start_cond = 1'b1;
                        seq_phase = PH_ADDR;
                    end
                    PH_ADDR: begin
                        if (it.bus_event) begin
                            r.addr_valid = 1'b1;
                            r.addr_byte = {dev_addr, 1'b1};
                            seq_phase = PH_ACKW;
                        end
                    end
                    PH_ACKW: begin
                        if (it.bus_event) begin
                            if (it.ack_status) begin
                                nack_latch = 1'b1;
                                seq_phase = (retry_cnt < retry_max) ? PH_RSTOP : PH_ESTOP;
                            end else begin
                                nack_latch = 1'b0;
                                retry_cnt = '0;
                                seq_phase = PH_RXEN;
                            end
                        end
                    end
                    PH_RXEN: begin
                        r.recv_enable = 1'b1;
                        seq_phase = PH_RXMID;
                    end
                    PH_RXMID: begin
                        if (it.bus_event) begin
                            r.rx_valid = 1'b1;
                            r.rx_index = byte_cnt[3:0];
                            r.rx_byte = it.rx_data;
                            r.ack_enable = 1'b1;
                            byte_cnt = byte_cnt + 5'd1;
                            seq_phase = PH_RXNEXT;
                        end
                    end
                    PH_RXNEXT: begin
                        if (it.bus_event) begin
                            r.recv_enable = 1'b1;
                            seq_phase = (int'(byte_cnt) + 1 < int'(eff_len)) ?
                                        PH_RXMID : PH_RXLAST;
                        end
                    end
                    PH_RXLAST: begin
                        if (it.bus_event) begin
                            r.rx_valid = 1'b1;
                            r.rx_index = byte_cnt[3:0];
                            r.rx_byte = it.rx_data;
                            r.ack_enable = 1'b1;
                            r.ack_level = 1'b1;
                            seq_phase = PH_NSTOP;
                        end
                    end
                    PH_RSTOP: begin
                        r.stop_cond = 1'b1;
                        seq_phase = PH_RWAIT;
                    end
                    PH_RWAIT: begin
                        if (it.bus_event) begin
                            retry_cnt = retry_cnt + 3'd1;
                            seq_phase = PH_START;
                        end
                    end
                    PH_ESTOP: begin
                        r.stop_cond = 1'b1;
                        seq_phase = PH_EWAIT;
                    end
                    PH_EWAIT: begin
                        if (it.bus_event) begin
                            r.finish_status = FINISH_FAIL;
                            done = 1'b1;
                        end
                    end
                    PH_NSTOP: begin
                        if (it.bus_event) begin
                            r.stop_cond = 1'b1;
                            seq_phase = PH_NWAIT;
                        end
                    end
                    PH_NWAIT: begin
                        if (it.bus_event) begin
                            r.finish_status = FINISH_OK;
                            done = 1'b1;
                        end
                    end
                    default: done = 1'b1;
                endcase
                if (done) begin
                    seq_phase = PH_IDLE;
                end else if (poll_cnt >= poll_limit) begin
                    r.finish_status = FINISH_FAIL;
                    seq_phase = PH_IDLE;
                end
            end
        end
        r.nack_seen = nack_latch;
        return r;
    endfunction

    function automatic in_item_t mk_in(logic mode, logic ev, logic nack, logic [7:0] rx);
        in_item_t it;
        it.mode = mode;
        it.bus_event = ev;
        it.ack_status = nack;
        it.rx_data = rx;
        return it;
    endfunction

    function automatic void add_item(in_item_t it, bit typed, out_item_t step);
        dir_row_t row;
        row = '{default: '0};
        row.item = it;
        row.typed = typed;
        row.step = step;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [6:0] addr, logic [4:0] len, logic [2:0] retry,
                                    logic [15:0] tmo);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.addr = addr;
        row.len = len;
        row.retry = retry;
        row.tmo = tmo;
        dir_rows.push_back(row);
    endfunction

    function automatic void note_error(string msg);
        bad_steps++;
        if (bad_steps <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Offer one transfer and record its predicted step once it is taken.
    task automatic send_item(in_item_t it, bit typed, out_item_t step);
        out_item_t predicted;
        s_valid <= 1'b1;
        s_data <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        predicted = advance_read_sequence(it);
        steps_due.push_back(typed ? step : predicted);
    endtask

    // Insert a short random gap on the input side.
    task automatic maybe_gap();
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted step has come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (steps_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all four registers, in index order.
    task automatic set_config(logic [6:0] addr, logic [4:0] len, logic [2:0] retry,
                              logic [15:0] tmo);
        logic [15:0] vals[4];
        logic [7:0]  idx[4];
        vals = '{16'(addr), 16'(len), 16'(retry), tmo};
        idx = '{REG_TARGET_ADDR, REG_READ_LENGTH, REG_RETRY_LIMIT, REG_TIMEOUT_LIMIT};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(negedge aclk);
            while (!cfg_ready) @(negedge aclk);
            @(posedge aclk);
            case (idx[i])
                REG_TARGET_ADDR:   dev_addr = vals[i][6:0];
                REG_READ_LENGTH:   rd_len = vals[i][4:0];
                REG_RETRY_LIMIT:   retry_max = vals[i][2:0];
                REG_TIMEOUT_LIMIT: poll_limit = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Generous run limit.
    initial begin
        #400000;
        $display("i2c_master_read_sequencer_tb: errors");
        $finish;
    end

    // Receiver: random short stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 40;
            end else if (stall_left == 0 && rx_stalls && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result check: a transfer is seen mid-cycle and completes at the next edge.
    always @(negedge aclk) begin : result_check
        out_item_t exp_step;
        string     diffs;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (steps_due.size() == 0) begin
                note_error($sformatf("unexpected result %p", m_data));
            end else begin
                exp_step = steps_due.pop_front();
                diffs = "";
                if (m_data.start_cond !== exp_step.start_cond) diffs = {diffs, " start_cond"};
                if (m_data.addr_valid !== exp_step.addr_valid) diffs = {diffs, " addr_valid"};
                if (m_data.addr_byte !== exp_step.addr_byte) diffs = {diffs, " addr_byte"};
                if (m_data.recv_enable !== exp_step.recv_enable) diffs = {diffs, " recv_enable"};
                if (m_data.ack_enable !== exp_step.ack_enable) diffs = {diffs, " ack_enable"};
                if (m_data.ack_level !== exp_step.ack_level) diffs = {diffs, " ack_level"};
                if (m_data.stop_cond !== exp_step.stop_cond) diffs = {diffs, " stop_cond"};
                if (m_data.rx_valid !== exp_step.rx_valid) diffs = {diffs, " rx_valid"};
                if (m_data.rx_index !== exp_step.rx_index) diffs = {diffs, " rx_index"};
                if (m_data.rx_byte !== exp_step.rx_byte) diffs = {diffs, " rx_byte"};
                if (m_data.finish_status !== exp_step.finish_status) begin
                    diffs = {diffs, " finish_status"};
                end
                if (m_data.nack_seen !== exp_step.nack_seen) diffs = {diffs, " nack_seen"};
                if (diffs != "") begin
                    note_error($sformatf("mismatch in%s: expected %p, got %p",
                                         diffs, exp_step, m_data));
                end
            end
        end
    end

    // Stimulus.
    initial begin
        in_item_t it;
        int       busy_items;
        logic [6:0]  addr;
        logic [4:0]  len;
        logic [2:0]  retry;
        logic [15:0] tmo;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        bad_steps = 0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        hold_req = 1'b0;

        // Shadow registers and state come up as the block does after reset.
        dev_addr = RST_TARGET_ADDR;
        rd_len = RST_READ_LENGTH;
        retry_max = RST_RETRY_LIMIT;
        poll_limit = RST_TIMEOUT_LIMIT;
        seq_phase = PH_IDLE;
        retry_cnt = '0;
        byte_cnt = '0;
        poll_cnt = '0;
        nack_latch = 1'b0;

        // Directed walk with reset registers: idle poll, ignored start, one NACK
        // with a retry, then a two-byte read with the last byte NACKed.
        add_item(mk_in(MODE_POLL, 1'b1, 1'b1, 8'hFF), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_START, 1'b0, 1'b0, 8'h00), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_START, 1'b1, 1'b1, 8'hFF), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b0, 1'b0, 8'h00), 1'b1,
                 out_item_t'{start_cond: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b0, 1'b0, 8'h00), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{addr_valid: 1'b1, addr_byte: 8'h01, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b1, 8'h00), 1'b1,
                 out_item_t'{nack_seen: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b0, 1'b0, 8'h00), 1'b1,
                 out_item_t'{stop_cond: 1'b1, nack_seen: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h5A), 1'b0, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'hA5), 1'b0, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b1, 1'b1, 8'h00), 1'b0, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b0, 1'b0, 8'h00), 1'b1,
                 out_item_t'{recv_enable: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'hFF), 1'b1,
                 out_item_t'{rx_valid: 1'b1, rx_byte: 8'hFF, ack_enable: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{recv_enable: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{rx_valid: 1'b1, rx_index: 4'd1, ack_enable: 1'b1,
                             ack_level: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b0, 1'b1, 8'hFF), 1'b0, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{stop_cond: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{finish_status: FINISH_OK, default: '0});
        // Top address, short read length and a poll budget that runs out mid-transaction.
        add_cfg(7'd127, 5'd0, 3'd0, 16'd3);
        add_item(mk_in(MODE_START, 1'b0, 1'b0, 8'h00), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b0, 1'b0, 8'h00), 1'b1,
                 out_item_t'{start_cond: 1'b1, default: '0});
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{addr_valid: 1'b1, addr_byte: 8'hFF, default: '0});
        add_item(mk_in(MODE_POLL, 1'b0, 1'b0, 8'h00), 1'b1,
                 out_item_t'{finish_status: FINISH_FAIL, default: '0});
        // A zero poll budget fails on the first poll.
        add_cfg(7'd127, 5'd0, 3'd0, 16'd0);
        add_item(mk_in(MODE_START, 1'b0, 1'b0, 8'h00), 1'b1, out_item_t'(0));
        add_item(mk_in(MODE_POLL, 1'b1, 1'b0, 8'h00), 1'b1,
                 out_item_t'{finish_status: FINISH_FAIL, default: '0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                settle();
                set_config(dir_rows[i].addr, dir_rows[i].len, dir_rows[i].retry,
                           dir_rows[i].tmo);
            end else begin
                maybe_gap();
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].step);
            end
        end

        // Random transactions, one register setting per round.
        for (int ph = 0; ph < 10; ph++) begin
            settle();
            case (ph)
                0: set_config(7'd127, 5'd31, 3'd7, 16'hFFFF);
                1: set_config(7'd0, 5'd0, 3'd0, 16'd1);
                2: set_config(7'($urandom_range(0, 127)), 5'd16, 3'd7, 16'hFFFF);
                default: begin
                    addr = 7'($urandom_range(0, 127));
                    len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                                        5'($urandom_range(0, 5));
                    retry = 3'($urandom_range(0, 7));
                    tmo = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 30)) :
                                                        16'($urandom_range(0, 65535));
                    set_config(addr, len, retry, tmo);
                end
            endcase
            // Round 2 keeps the input busy during a long output hold-off; round 3
            // and the last two rounds run without idling.
            tx_gaps = (ph != 2 && ph != 3 && ph < 8);
            rx_stalls = (ph != 3 && ph < 8);
            if (ph == 2) hold_req = 1'b1;
            busy_items = 0;
            while (busy_items < 50) begin
                if (seq_phase == PH_IDLE) begin
                    it = mk_in(($urandom_range(0, 3) != 0) ? MODE_START : MODE_POLL,
                               1'($urandom), 1'($urandom), 8'($urandom));
                end else if ($urandom_range(0, 15) == 0) begin
                    it = mk_in(MODE_START, 1'($urandom), 1'($urandom), 8'($urandom));
                end else begin
                    it = mk_in(MODE_POLL, $urandom_range(0, 3) != 0,
                               $urandom_range(0, 3) == 0, 8'($urandom));
                end
                if ((it.mode == MODE_START) == (seq_phase == PH_IDLE)) busy_items++;
                maybe_gap();
                send_item(it, 1'b0, out_item_t'(0));
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        if (bad_steps == 0 && steps_due.size() == 0) begin
            $display("i2c_master_read_sequencer_tb: clean");
        end else begin
            $display("i2c_master_read_sequencer_tb: errors");
        end
        $finish;
    end

endmodule

// File: i2c_master_read_sequencer.f
rtl/core/i2cmrs_pkg.sv
rtl/core/i2cmrs_step.sv
rtl/core/i2c_master_read_sequencer.sv
dv/i2c_master_read_sequencer_tb.sv
